@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the rasterizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/aalr_pkg.sv @@
// ----------------------------------------------------------------------------
// aalr_pkg
// Types shared by the antialiased line rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package aalr_pkg;

    // Request kinds carried in tuser.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DXSQ,
        S_DYSQ,
        S_SUM,
        S_TGT,
        S_TGT2,
        S_CSQ,
        S_CPROD,
        S_CMP,
        S_COV0,
        S_COV1,
        S_COV2,
        S_COV3,
        S_EMIT
    } state_t;

endpackage

@@ sv/antialiased_line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_core
// Gupta-Sproull style antialiased line rasterizer with one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes requests: tuser = 0 starts a first-octant line from
// the end points in tdata, tuser = 1 asks for the next column. The master
// stream returns one transaction per step while a line is active: column,
// centre row, three alphas, the stroke colour, and tlast on the final column.
// A start computes the unit steps bit by bit with one multiplier; each
// quotient bit squares the candidate, scales it by the squared length and
// compares. A rejected start or a step without a line leaves the block idle.
// A step makes three squarings through the same multiplier, then loads the
// output register. Input is ready only in the idle state.
// Reset clears the line state and the stroke colour. When the receiver
// stalls, the result holds in the output register and the block waits in
// its emit state until the register is free.
// cfg_we writes stroke_rgb; write it only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module antialiased_line_rasterizer_core #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 12
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // x_start, y_start, x_end, y_end from bit 0 up, zero padded to bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // col_x, row_y, alpha_above, alpha_centre, alpha_below, pixel_rgb from bit 0 up
    output logic [((2*COORD_BITS+48+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast,
    input  logic cfg_we,
    input  logic [23:0] cfg_wdata
);

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int MW   = (2*C+1 > 2*F+1) ? 2*C+1 : 2*F+1;
    localparam int PW   = 2*MW;
    localparam int DW   = F+4;
    localparam int DECW = C+3;
    localparam int BW   = $clog2(F+1);
    localparam int OW   = ((2*C+48+7)/8)*8;
    localparam logic [F:0]      ONE_Q = {1'b1, {F{1'b0}}};
    localparam logic [PW-1:0]   ONE_T = {{(PW-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};
    localparam logic signed [DW+1:0] DMAX = {3'b000, {(DW-1){1'b1}}};
    localparam logic signed [DW+1:0] DMIN = {3'b111, {(DW-1){1'b0}}};

    aalr_pkg::state_t state_reg, state_next;

    logic [23:0]      stroke_reg;
    logic             active_reg, active_next;
    logic [C-1:0]     cur_x_reg, cur_x_next, cur_y_reg, cur_y_next, end_x_reg, end_x_next;
    logic signed [DECW-1:0] dec_reg, dec_next;
    logic signed [DW-1:0]   dist_reg, dist_next;
    logic [F:0]       across_reg, across_next, along_reg, along_next;
    logic [C-1:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic [2*C:0]     sq_reg, sq_next;
    logic [PW-1:0]    tgt_reg, tgt_next;
    logic [F:0]       q_reg, q_next;
    logic [BW-1:0]    bit_reg, bit_next;
    logic             sel_reg, sel_next;
    logic [7:0]       a_up_reg, a_up_next, a_mid_reg, a_mid_next;
    logic [PW-1:0]    prod_reg;
    logic [MW-1:0]    mul_a, mul_b;

    logic             out_valid_reg, out_valid_next;
    logic [OW-1:0]    out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;

    // Input field views.
    logic [C-1:0] in_xs, in_ys, in_xe, in_ye;
    assign in_xs = s_axis_tdata[C-1:0];
    assign in_ys = s_axis_tdata[2*C-1:C];
    assign in_xe = s_axis_tdata[3*C-1:2*C];
    assign in_ye = s_axis_tdata[4*C-1:3*C];

    logic in_acc, emit_go, start_ok, at_end;
    logic [C-1:0] in_dx, in_dy;
    assign s_axis_tready = (state_reg == aalr_pkg::S_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign emit_go = !out_valid_reg || m_axis_tready;
    assign in_dx   = in_xe - in_xs;
    assign in_dy   = in_ye - in_ys;
    assign start_ok = (in_xe >= in_xs) && (in_ye >= in_ys) && (in_dy <= in_dx);
    assign at_end  = (cur_x_reg == end_x_reg);

    // Candidate quotient with the current bit set.
    logic [F:0] cand;
    assign cand = q_reg | (ONE_Q >> (F[BW-1:0] - bit_reg));

    // Coverage distances and magnitudes.
    logic signed [DW:0] r_up, r_mid, r_dn;
    logic [DW:0] m_up, m_mid, m_dn;
    assign r_up  = {dist_reg[DW-1], dist_reg} + $signed({1'b0, {(DW-F-1){1'b0}}, across_reg});
    assign r_mid = {dist_reg[DW-1], dist_reg};
    assign r_dn  = {dist_reg[DW-1], dist_reg} - $signed({1'b0, {(DW-F-1){1'b0}}, across_reg});
    assign m_up  = r_up[DW]  ? -r_up  : r_up;
    assign m_mid = r_mid[DW] ? -r_mid : r_mid;
    assign m_dn  = r_dn[DW]  ? -r_dn  : r_dn;

    // Alpha from the squared distance in the product register.
    logic [2*F:0]   cov_d;
    logic [2*F+8:0] cov_x;
    logic [7:0]     alpha;
    assign cov_d = ONE_T[2*F:0] - prod_reg[2*F:0];
    assign cov_x = {cov_d, 8'd0} - {8'd0, cov_d};
    assign alpha = (prod_reg >= ONE_T) ? 8'd0 : cov_x[2*F+7:2*F];

    // Next distance and decision for a column advance.
    logic signed [DW+1:0] dsum;
    logic signed [DECW-1:0] two_dy, two_dx;
    assign two_dy = $signed({2'b00, dy_reg, 1'b0});
    assign two_dx = $signed({2'b00, dx_reg, 1'b0});
    assign dsum = {{2{dist_reg[DW-1]}}, dist_reg}
                + $signed({{(DW+1-F){1'b0}}, along_reg})
                - ((dec_reg > 0) ? $signed({{(DW+1-F){1'b0}}, across_reg})
                                 : $signed({(DW+2){1'b0}}));

    // Shared multiplier, registered.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Sequencer, next state and datapath.
    always_comb
    begin
        state_next = state_reg;
        active_next = active_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        end_x_next = end_x_reg;
        dec_next = dec_reg;
        dist_next = dist_reg;
        across_next = across_reg;
        along_next = along_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        sq_next = sq_reg;
        tgt_next = tgt_reg;
        q_next = q_reg;
        bit_next = bit_reg;
        sel_next = sel_reg;
        a_up_next = a_up_reg;
        a_mid_next = a_mid_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            aalr_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser == aalr_pkg::REQ_START)
                    begin
                        if (start_ok)
                        begin
                            dx_next = in_dx;
                            dy_next = in_dy;
                            cur_x_next = in_xs;
                            cur_y_next = in_ys;
                            end_x_next = in_xe;
                            dec_next = $signed({2'b00, in_dy, 1'b0}) - $signed({3'b000, in_dx});
                            dist_next = '0;
                            active_next = 1'b1;
                            state_next = aalr_pkg::S_DXSQ;
                        end
                    end
                    else if (active_reg)
                    begin
                        state_next = aalr_pkg::S_COV0;
                    end
                end
            end
            aalr_pkg::S_DXSQ:
            begin
                mul_a = MW'(dx_reg);
                mul_b = MW'(dx_reg);
                state_next = aalr_pkg::S_DYSQ;
            end
            aalr_pkg::S_DYSQ:
            begin
                mul_a = MW'(dy_reg);
                mul_b = MW'(dy_reg);
                sq_next = prod_reg[2*C:0];
                state_next = aalr_pkg::S_SUM;
            end
            aalr_pkg::S_SUM:
            begin
                sq_next = sq_reg + prod_reg[2*C:0];
                sel_next = 1'b0;
                state_next = aalr_pkg::S_TGT;
            end
            aalr_pkg::S_TGT:
            begin
                mul_a = MW'(sel_reg ? dy_reg : dx_reg);
                mul_b = MW'(sel_reg ? dy_reg : dx_reg);
                state_next = aalr_pkg::S_TGT2;
            end
            aalr_pkg::S_TGT2:
            begin
                tgt_next = PW'({prod_reg[2*C-1:0], {(2*F){1'b0}}});
                q_next = '0;
                bit_next = F[BW-1:0];
                state_next = aalr_pkg::S_CSQ;
            end
            aalr_pkg::S_CSQ:
            begin
                mul_a = MW'(cand);
                mul_b = MW'(cand);
                state_next = aalr_pkg::S_CPROD;
            end
            aalr_pkg::S_CPROD:
            begin
                mul_a = prod_reg[MW-1:0];
                mul_b = MW'(sq_reg);
                state_next = aalr_pkg::S_CMP;
            end
            aalr_pkg::S_CMP:
            begin
                if ((cand <= ONE_Q) && (prod_reg <= tgt_reg) && (sq_reg != '0))
                begin
                    q_next = cand;
                end
                if (bit_reg == '0)
                begin
                    if (!sel_reg)
                    begin
                        across_next = q_next;
                        sel_next = 1'b1;
                        state_next = aalr_pkg::S_TGT;
                    end
                    else
                    begin
                        along_next = q_next;
                        state_next = aalr_pkg::S_IDLE;
                    end
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                    state_next = aalr_pkg::S_CSQ;
                end
            end
            aalr_pkg::S_COV0:
            begin
                mul_a = MW'(m_up);
                mul_b = MW'(m_up);
                state_next = aalr_pkg::S_COV1;
            end
            aalr_pkg::S_COV1:
            begin
                mul_a = MW'(m_mid);
                mul_b = MW'(m_mid);
                a_up_next = alpha;
                state_next = aalr_pkg::S_COV2;
            end
            aalr_pkg::S_COV2:
            begin
                mul_a = MW'(m_dn);
                mul_b = MW'(m_dn);
                a_mid_next = alpha;
                state_next = aalr_pkg::S_COV3;
            end
            aalr_pkg::S_COV3:
            begin
                // Below alpha is taken straight from the product in the emit state.
                state_next = aalr_pkg::S_EMIT;
                mul_a = MW'(m_dn);
                mul_b = MW'(m_dn);
            end
            aalr_pkg::S_EMIT:
            begin
                mul_a = MW'(m_dn);
                mul_b = MW'(m_dn);
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_last_next = at_end;
                    out_data_next = OW'({stroke_reg, alpha, a_mid_reg, a_up_reg,
                                         cur_y_reg, cur_x_reg});
                    if (at_end)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + 1'b1;
                        if (dsum > DMAX)
                            dist_next = DMAX[DW-1:0];
                        else if (dsum < DMIN)
                            dist_next = DMIN[DW-1:0];
                        else
                            dist_next = dsum[DW-1:0];
                        if (dec_reg <= 0)
                        begin
                            dec_next = dec_reg + two_dy;
                        end
                        else
                        begin
                            dec_next = dec_reg + two_dy - two_dx;
                            cur_y_next = cur_y_reg + 1'b1;
                        end
                    end
                    state_next = aalr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = aalr_pkg::S_IDLE;
            end
        endcase
    end

    // Control and line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aalr_pkg::S_IDLE;
            stroke_reg <= '0;
            active_reg <= 1'b0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            end_x_reg <= '0;
            dec_reg <= '0;
            dist_reg <= '0;
            across_reg <= '0;
            along_reg <= '0;
            dx_reg <= '0;
            dy_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                stroke_reg <= cfg_wdata;
            end
            active_reg <= active_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            end_x_reg <= end_x_next;
            dec_reg <= dec_next;
            dist_reg <= dist_next;
            across_reg <= across_next;
            along_reg <= along_next;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
        tgt_reg <= tgt_next;
        q_reg <= q_next;
        bit_reg <= bit_next;
        sel_reg <= sel_next;
        a_up_reg <= a_up_next;
        a_mid_reg <= a_mid_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks.
    `ASSERT_NEXT(a_step_idle, clk, rst_n,
        in_acc && s_axis_tuser == aalr_pkg::REQ_STEP && !active_reg,
        state_reg == aalr_pkg::S_IDLE)
    `ASSERT_NEXT(a_last_clears, clk, rst_n,
        state_reg == aalr_pkg::S_EMIT && emit_go && at_end, !active_reg)
    `ASSERT_IMPL(a_q_bound, clk, rst_n,
        state_reg == aalr_pkg::S_CMP, q_reg <= ONE_Q)
    `ASSERT_IMPL(a_step_order, clk, rst_n,
        state_reg == aalr_pkg::S_IDLE && active_reg, across_reg >= along_reg)

endmodule

@@ verif/antialiased_line_rasterizer_core_test.sv @@
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_core_test
// Drives start and step transactions with random gaps and receiver stalls.
// A scoreboard class predicts each column and checks the master stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module antialiased_line_rasterizer_core_test;

    localparam int CB = 12;
    localparam int FB = 12;
    localparam int IN_W = ((4*CB+7)/8)*8;
    localparam int OUT_W = ((2*CB+48+7)/8)*8;
    localparam int LIMIT = 20000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0] a_above;
        logic [7:0] a_centre;
        logic [7:0] a_below;
        logic [23:0] rgb;
        logic fin;
    } column_t;

    // Line tracker and store of expected columns.
    class column_scoreboard;
        bit [23:0] stroke;
        bit on;
        bit [11:0] x, y, xe;
        longint dec, dist_acc;
        longint across, along, ddx, ddy;
        column_t pending[$];
        int errors;

        function longint unit_frac(longint num, longint sq);
            longint q, c, tgt;
            q = 0;
            tgt = (num << FB) * (num << FB);
            if (sq == 0)
                return 0;
            for (int b = FB; b >= 0; b--)
            begin
                c = q | (longint'(1) << b);
                if (c <= (longint'(1) << FB) && c * c * sq <= tgt)
                    q = c;
            end
            return q;
        endfunction

        function bit [7:0] alpha(longint r);
            longint t, one;
            one = longint'(1) << (2*FB);
            t = r * r;
            if (t >= one)
                return 0;
            return 8'((255 * (one - t)) >> (2*FB));
        endfunction

        function longint clip(longint v);
            if (v > (longint'(1) << (FB+3)) - 1)
                return (longint'(1) << (FB+3)) - 1;
            if (v < -(longint'(1) << (FB+3)))
                return -(longint'(1) << (FB+3));
            return v;
        endfunction

        function void note_request(bit kind, bit [11:0] xs, bit [11:0] ys,
                                   bit [11:0] xe_i, bit [11:0] ye);
            column_t c;
            longint sq;
            if (kind == aalr_pkg::REQ_START)
            begin
                if (xe_i < xs || ye < ys || (ye - ys) > (xe_i - xs))
                    return;
                ddx = xe_i - xs;
                ddy = ye - ys;
                sq = ddx * ddx + ddy * ddy;
                across = unit_frac(ddx, sq);
                along = unit_frac(ddy, sq);
                dec = 2 * ddy - ddx;
                dist_acc = 0;
                x = xs;
                y = ys;
                xe = xe_i;
                on = 1;
                return;
            end
            if (!on)
                return;
            c.col = x;
            c.row = y;
            c.a_above = alpha(dist_acc + across);
            c.a_centre = alpha(dist_acc);
            c.a_below = alpha(dist_acc - across);
            c.rgb = stroke;
            c.fin = (x == xe);
            pending.push_back(c);
            if (c.fin)
                on = 0;
            else
            begin
                x = x + 1;
                if (dec <= 0)
                begin
                    dist_acc = clip(dist_acc + along);
                    dec += 2 * ddy;
                end
                else
                begin
                    dist_acc = clip(dist_acc + along - across);
                    dec += 2 * (ddy - ddx);
                    y = y + 1;
                end
            end
        endfunction

        function void check_column(column_t got);
            column_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected column %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_we = 0;
    logic [23:0] cfg_wdata = '0;

    column_scoreboard board = new();
    int idle_cycles = 0;
    bit hold_req = 0;
    bit sending_done = 0;

    antialiased_line_rasterizer_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #6 clk = ~clk;

    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // One request transaction; waits for acceptance, then a random gap when gaps is set.
    task automatic send_req(bit kind, bit [11:0] xs, bit [11:0] ys,
                            bit [11:0] xe, bit [11:0] ye, bit gaps);
        int g;
        s_axis_tvalid <= 1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {ye, xe, ys, xs};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_request(kind, xs, ys, xe, ye);
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    // A start followed by the given number of step requests.
    task automatic run_line(bit [11:0] xs, bit [11:0] ys, bit [11:0] xe,
                            bit [11:0] ye, int steps);
        send_req(aalr_pkg::REQ_START, xs, ys, xe, ye, 1);
        for (int i = 0; i < steps; i++)
            send_req(aalr_pkg::REQ_STEP, 12'($urandom), 12'($urandom), 12'($urandom),
                     12'($urandom), 1);
    endtask

    task automatic set_stroke(bit [23:0] v);
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        board.stroke = v;
    endtask

    // Receiver side: random stalls, one long hold-off, result checks.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_column(column_t'({m_axis_tdata[11:0],
                    m_axis_tdata[23:12], m_axis_tdata[31:24],
                    m_axis_tdata[39:32], m_axis_tdata[47:40],
                    m_axis_tdata[71:48], m_axis_tlast}));
        end
    end

    initial
    begin
        int k;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // Long hold-off, counted here while the sender keeps offering.
                m_axis_tready <= 0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                k = $urandom_range(0, 99);
                m_axis_tready <= (k < 70);
                if (k >= 98)
                    repeat ($urandom_range(5, 40)) @(posedge clk);
            end
        end
    end

    // Watchdog on cycles with no accepted transaction.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            !rst_n || !s_axis_tvalid && sending_done == 0 && board.pending.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT)
        begin
            $display("antialiased_line_rasterizer_core_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int n, len, dy, xs, ys, kind;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: steps with no line, zero length, extremes, rejected starts.
        send_req(aalr_pkg::REQ_STEP, 0, 0, 0, 0, 0);
        run_line(100, 200, 100, 200, 2);
        run_line(0, 0, 4095, 4095, 0);
        run_line(0, 0, 8, 0, 9);
        run_line(10, 10, 16, 16, 7);
        send_req(aalr_pkg::REQ_START, 50, 50, 40, 50, 0);
        send_req(aalr_pkg::REQ_START, 50, 50, 60, 40, 0);
        send_req(aalr_pkg::REQ_START, 50, 50, 52, 60, 0);
        send_req(aalr_pkg::REQ_STEP, 0, 0, 0, 0, 0);
        set_stroke(24'hFFFFFF);
        run_line(4090, 4093, 4095, 4095, 6);
        run_line(0, 0, 4095, 1, 3);
        set_stroke(24'h000000);

        // Long receiver hold-off while requests keep coming.
        hold_req = 1;
        run_line(20, 30, 40, 37, 12);
        run_line(0, 0, 0, 0, 10);

        // Random phase: mostly well-formed lines, some noise.
        n = 0;
        while (n < 1300)
        begin
            if (n % 300 == 299)
                set_stroke(24'($urandom));
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 20);
                xs = $urandom_range(0, 4095 - len);
                dy = $urandom_range(0, len);
                ys = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 4095 - dy);
                send_req(aalr_pkg::REQ_START, 12'(xs), 12'(ys), 12'(xs + len),
                         12'(ys + dy), 1);
                len = (len > 30) ? $urandom_range(1, 30) : len + $urandom_range(0, 2);
                for (int i = 0; i < len + 1; i++)
                    send_req(aalr_pkg::REQ_STEP, 12'($urandom), 12'($urandom),
                             12'($urandom), 12'($urandom), 1);
                n += len + 2;
            end
            else
            begin
                send_req(1'($urandom_range(0, 1)), 12'($urandom), 12'($urandom),
                         12'($urandom), 12'($urandom), 1);
                n++;
            end
        end
        s_axis_tvalid <= 0;
        sending_done = 1;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("antialiased_line_rasterizer_core_test: done, clean");
        else
            $display("antialiased_line_rasterizer_core_test: done, errors");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+sv
sv/aalr_pkg.sv
sv/antialiased_line_rasterizer_core.sv
verif/antialiased_line_rasterizer_core_test.sv
